[rtl/rpa_pkg.sv]
package rpa_pkg;

  localparam int CordicStages = 16;
  localparam int AtanEntries = 24;
  localparam int NStages = (CordicStages < AtanEntries) ? CordicStages : AtanEntries;

  localparam logic signed [31:0] TwoPi = 32'sd1686629713;
  localparam logic signed [31:0] Pi = 32'sd843314857;
  localparam logic signed [31:0] HalfPi = 32'sd421657428;
  localparam logic signed [31:0] InvGain = 32'sd652032874;

  function automatic logic signed [31:0] atan_q28(input int i);
    logic signed [31:0] r;
    begin
      case (i)
        0: r = 32'sd210828714;
        1: r = 32'sd124459457;
        2: r = 32'sd65760959;
        3: r = 32'sd33381290;
        4: r = 32'sd16755422;
        5: r = 32'sd8385879;
        6: r = 32'sd4193963;
        7: r = 32'sd2097109;
        8: r = 32'sd1048571;
        9: r = 32'sd524287;
        10: r = 32'sd262144;
        11: r = 32'sd131072;
        12: r = 32'sd65536;
        13: r = 32'sd32768;
        14: r = 32'sd16384;
        15: r = 32'sd8192;
        16: r = 32'sd4096;
        17: r = 32'sd2048;
        18: r = 32'sd1024;
        19: r = 32'sd512;
        20: r = 32'sd256;
        21: r = 32'sd128;
        22: r = 32'sd64;
        23: r = 32'sd32;
        default: r = 32'sd0;
      endcase
      return r;
    end
  endfunction

  typedef struct packed {
    logic signed [21:0] cos_v;
    logic signed [21:0] sin_v;
  } trig_t;

endpackage

[rtl/rpa_cordic.sv]
module rpa_cordic (
  input  logic clk,
  input  logic signed [15:0] angle,
  output rpa_pkg::trig_t trig
);
  import rpa_pkg::*;

  logic signed [31:0] zr;
  logic signed [31:0] zr2;
  logic neg0;
  logic signed [31:0] zf;
  logic signed [32:0] xs [0:NStages];
  logic signed [32:0] ys [0:NStages];
  logic signed [31:0] zs [0:NStages];
  logic negs [0:NStages];
  logic signed [32:0] cr;
  logic signed [32:0] sr;

  // Q4.12 times 2^16 lies within about +-8 rad, so at most two wraps are needed.
  always_comb begin
    zr = {angle, 16'd0};
    if (zr > Pi) begin
      zr = zr - TwoPi;
    end else if (zr < -Pi) begin
      zr = zr + TwoPi;
    end
    if (zr > Pi) begin
      zr = zr - TwoPi;
    end else if (zr < -Pi) begin
      zr = zr + TwoPi;
    end
  end

  always_ff @(posedge clk) begin
    zr2 <= zr;
  end

  always_comb begin
    neg0 = 1'b0;
    zf = zr2;
    if (zr2 > HalfPi) begin
      zf = zr2 - Pi;
      neg0 = 1'b1;
    end else if (zr2 < -HalfPi) begin
      zf = zr2 + Pi;
      neg0 = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    xs[0] <= 33'(InvGain);
    ys[0] <= '0;
    zs[0] <= zf;
    negs[0] <= neg0;
  end

  for (genvar i = 0; i < NStages; i++) begin : g_stage
    always_ff @(posedge clk) begin
      if (zs[i] >= 0) begin
        xs[i+1] <= xs[i] - (ys[i] >>> i);
        ys[i+1] <= ys[i] + (xs[i] >>> i);
        zs[i+1] <= zs[i] - atan_q28(i);
      end else begin
        xs[i+1] <= xs[i] + (ys[i] >>> i);
        ys[i+1] <= ys[i] - (xs[i] >>> i);
        zs[i+1] <= zs[i] + atan_q28(i);
      end
      negs[i+1] <= negs[i];
    end
  end

  always_comb begin
    cr = (xs[NStages] + 33'sd512) >>> 10;
    sr = (ys[NStages] + 33'sd512) >>> 10;
  end

  always_ff @(posedge clk) begin
    trig.cos_v <= negs[NStages] ? -cr[21:0] : cr[21:0];
    trig.sin_v <= negs[NStages] ? -sr[21:0] : sr[21:0];
  end

endmodule

[rtl/rpa_vector.sv]
module rpa_vector (
  input  logic clk,
  input  logic signed [14:0] ax,
  input  logic signed [14:0] ay,
  input  logic signed [14:0] az,
  input  logic signed [31:0] px,
  input  logic signed [31:0] py,
  input  logic signed [31:0] pz,
  input  logic signed [31:0] qx,
  input  logic signed [31:0] qy,
  input  logic signed [31:0] qz,
  output logic signed [35:0] ux,
  output logic signed [35:0] uy,
  output logic signed [35:0] uz,
  output logic signed [36:0] vx,
  output logic signed [36:0] vy,
  output logic signed [36:0] vz
);
  import rpa_pkg::*;

  logic signed [14:0] a1 [3];
  logic signed [32:0] d1 [3];
  logic signed [14:0] a2 [3];
  logic signed [32:0] d2 [3];
  logic signed [47:0] m2 [3];
  logic signed [14:0] a3 [3];
  logic signed [32:0] d3 [3];
  logic signed [49:0] sum3;
  logic signed [35:0] dot4;
  logic signed [14:0] a4 [3];
  logic signed [32:0] d4 [3];
  logic signed [50:0] pr5 [3];
  logic signed [14:0] a5 [3];
  logic signed [32:0] d5 [3];
  logic signed [35:0] u6 [3];
  logic signed [14:0] a6 [3];
  logic signed [50:0] cp7 [6];
  logic signed [35:0] u7 [3];
  logic signed [51:0] df [3];
  logic signed [51:0] pt [3];

  always_ff @(posedge clk) begin
    a1[0] <= ax; a1[1] <= ay; a1[2] <= az;
    d1[0] <= 33'(qx) - 33'(px);
    d1[1] <= 33'(qy) - 33'(py);
    d1[2] <= 33'(qz) - 33'(pz);
    for (int k = 0; k < 3; k++) begin
      a2[k] <= a1[k];
      d2[k] <= d1[k];
      m2[k] <= 48'(a1[k]) * 48'(d1[k]);
      a3[k] <= a2[k];
      d3[k] <= d2[k];
      a4[k] <= a3[k];
      d4[k] <= d3[k];
      a5[k] <= a4[k];
      d5[k] <= d4[k];
      pr5[k] <= 51'(a4[k]) * 51'(dot4);
      a6[k] <= a5[k];
      u6[k] <= 36'(d5[k]) - 36'((pr5[k] + 51'sd8192) >>> 14);
      u7[k] <= u6[k];
    end
    sum3 <= 50'(m2[0]) + 50'(m2[1]) + 50'(m2[2]);
    dot4 <= 36'((sum3 + 50'sd8192) >>> 14);
    cp7[0] <= 51'(a6[1]) * 51'(u6[2]);
    cp7[1] <= 51'(a6[2]) * 51'(u6[1]);
    cp7[2] <= 51'(a6[2]) * 51'(u6[0]);
    cp7[3] <= 51'(a6[0]) * 51'(u6[2]);
    cp7[4] <= 51'(a6[0]) * 51'(u6[1]);
    cp7[5] <= 51'(a6[1]) * 51'(u6[0]);
  end

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      df[k] = 52'(cp7[2*k]) - 52'(cp7[2*k+1]);
      pt[k] = (df[k] + 52'sd8192) >>> 14;
    end
  end

  always_ff @(posedge clk) begin
    ux <= u7[0]; uy <= u7[1]; uz <= u7[2];
    vx <= pt[0][36:0]; vy <= pt[1][36:0]; vz <= pt[2][36:0];
  end

endmodule

[rtl/rotate_point_about_axis_unit.sv]
// Rotates a position about an axis and returns rotated minus original position.
// The pipeline takes one item every cycle and busy is always low; each result
// appears with done high for one cycle, after a delay that grows with the
// CORDIC stage count. The receiver cannot stall.
module rotate_point_about_axis_unit (
  input  logic clk,
  input  logic rst,
  input  logic start,
  output logic busy,
  input  logic signed [14:0] axis_x,
  input  logic signed [14:0] axis_y,
  input  logic signed [14:0] axis_z,
  input  logic signed [15:0] angle,
  input  logic signed [31:0] pivot_x,
  input  logic signed [31:0] pivot_y,
  input  logic signed [31:0] pivot_z,
  input  logic signed [31:0] pos_x,
  input  logic signed [31:0] pos_y,
  input  logic signed [31:0] pos_z,
  output logic done,
  output logic signed [31:0] offset_x,
  output logic signed [31:0] offset_y,
  output logic signed [31:0] offset_z,
  output logic saturated
);
  import rpa_pkg::*;

  localparam int Lat = NStages + 2;
  localparam int VecLat = 8;

  trig_t trig;
  logic signed [35:0] ux, uy, uz;
  logic signed [36:0] vx, vy, vz;
  logic signed [35:0] ue [3];
  logic signed [35:0] uf [3];
  logic signed [57:0] pc [3];
  logic signed [57:0] ps [3];
  logic signed [35:0] ug [3];
  logic signed [58:0] rs [3];
  logic signed [39:0] r [3];
  logic signed [40:0] o [3];
  logic sat [3];
  logic [Lat+3:0] vld;

  rpa_cordic u_cordic (.clk(clk), .angle(angle), .trig(trig));
  rpa_vector u_vector (.clk(clk), .ax(axis_x), .ay(axis_y), .az(axis_z),
    .px(pivot_x), .py(pivot_y), .pz(pivot_z), .qx(pos_x), .qy(pos_y), .qz(pos_z),
    .ux(ux), .uy(uy), .uz(uz), .vx(vx), .vy(vy), .vz(vz));

  logic signed [35:0] udl [3][Lat-VecLat+1];
  logic signed [36:0] vdl [3][Lat-VecLat+1];

  always_ff @(posedge clk) begin
    udl[0][0] <= ux; udl[1][0] <= uy; udl[2][0] <= uz;
    vdl[0][0] <= vx; vdl[1][0] <= vy; vdl[2][0] <= vz;
    for (int k = 0; k < 3; k++) begin
      for (int j = 1; j <= Lat - VecLat; j++) begin
        udl[k][j] <= udl[k][j-1];
        vdl[k][j] <= vdl[k][j-1];
      end
      uf[k] <= udl[k][Lat-VecLat];
      pc[k] <= 58'(udl[k][Lat-VecLat]) * 58'(trig.cos_v);
      ps[k] <= 58'(vdl[k][Lat-VecLat]) * 58'(trig.sin_v);
      ug[k] <= uf[k];
      rs[k] <= 59'(pc[k]) + 59'(ps[k]);
    end
  end

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      ue[k] = ug[k];
      r[k] = 40'((rs[k] + 59'sd524288) >>> 20);
      o[k] = 41'(r[k]) - 41'(ue[k]);
      sat[k] = (o[k] > 41'sd2147483647) || (o[k] < -41'sd2147483648);
    end
  end

  always_ff @(posedge clk) begin
    offset_x <= sat[0] ? (o[0][40] ? 32'sh80000000 : 32'sh7fffffff) : o[0][31:0];
    offset_y <= sat[1] ? (o[1][40] ? 32'sh80000000 : 32'sh7fffffff) : o[1][31:0];
    offset_z <= sat[2] ? (o[2][40] ? 32'sh80000000 : 32'sh7fffffff) : o[2][31:0];
    saturated <= sat[0] | sat[1] | sat[2];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      vld <= {vld[Lat+2:0], start};
    end
  end

  assign busy = 1'b0;
  assign done = vld[Lat+3];

  assert property (@(posedge clk) disable iff (rst) !busy);
  assert property (@(posedge clk) disable iff (rst) vld[0] |-> $past(start))
    else $error("valid without start");
  assert property (@(posedge clk) disable iff (rst)
    done && saturated |->
    (offset_x == 32'sh7fffffff || offset_x == 32'sh80000000 ||
     offset_y == 32'sh7fffffff || offset_y == 32'sh80000000 ||
     offset_z == 32'sh7fffffff || offset_z == 32'sh80000000))
    else $error("flag mismatch");

endmodule
